// ===== rtl/hth_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 hysteresis threshold block.
// No dependencies; the files that use it refer to it by scoped names.
package hth_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int THR_W      = 8;

  localparam logic [PIX_W-1:0] FULL_LEVEL = 8'd255;

  localparam logic [THR_W-1:0] HIGH_THR_RST = 8'd200;
  localparam logic [THR_W-1:0] LOW_THR_RST  = 8'd100;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_WIDTH    = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_idx_t;

  // bit 0: strong, bit 1: candidate
  typedef logic [1:0] flags_t;
  localparam int FLAG_STRONG_BIT = 0;
  localparam int FLAG_CAND_BIT   = 1;

  // one line-store entry: [1:0] two rows up, [3:2] one row up
  typedef logic [3:0] row_ent_t;

  // 3x3 window, column-major, left column lowest, two bits a cell
  typedef logic [17:0] window_t;

  typedef struct packed {
    flags_t flags;
    logic   first_col;
    logic   row_ge1;
    logic   row_ge2;
    logic   emit;
    logic   frame_end;
  } pix_pkt_t;

  function automatic flags_t classify(input logic [PIX_W-1:0] pix,
                                      input logic [THR_W-1:0] high_thr,
                                      input logic [THR_W-1:0] low_thr);
    logic             is_strong;
    logic [PIX_W-1:0] level;
    flags_t           f;
    is_strong = (pix > high_thr) || (pix == FULL_LEVEL);
    level     = is_strong ? FULL_LEVEL : pix;
    f[FLAG_STRONG_BIT] = is_strong;
    f[FLAG_CAND_BIT]   = (level > low_thr);
    return f;
  endfunction

  // centre candidate and any strong neighbour (centre strength excluded)
  function automatic logic centre_edge(input window_t w);
    logic any;
    any = w[0] | w[2] | w[4] | w[6] | w[10] | w[12] | w[14] | w[16];
    return w[9] & any;
  endfunction

endpackage

// ===== rtl/hth_in_if.sv =====
// Input channel of the hysteresis threshold block: valid/ready plus op and pixel.
// Depends on hth_pkg.
interface hth_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [hth_pkg::PIX_W-1:0]     pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

// ===== rtl/hth_out_if.sv =====
// Result channel of the hysteresis threshold block: valid/ready plus edge and frame end.
// Depends on nothing.
interface hth_out_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic frame_end;

  modport source (output valid, output edge_res, output frame_end, input ready);
  modport sink   (input valid, input edge_res, input frame_end, output ready);
endinterface

// ===== rtl/hth_front.sv =====
// Front stage: configuration registers, raster position and output counters, pixel classing.
// Depends on hth_pkg.
module hth_front #(
  parameter int MAX_WIDTH  = hth_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hth_pkg::MAX_HEIGHT_DEF,
  localparam int XW = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hth_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hth_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_op,
  input  logic [hth_pkg::PIX_W-1:0]         in_pixel,
  output logic                              in_ready,
  input  logic                              s1_ready,
  output logic                              acc,
  output hth_pkg::pix_pkt_t                 pkt,
  output logic [XW-1:0]                     pkt_x
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  // the input row runs one past the frame while draining
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RST = (hth_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : hth_pkg::WIDTH_RST;
  localparam int H_RST = (hth_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : hth_pkg::HEIGHT_RST;

  logic [hth_pkg::THR_W-1:0] high_thr_r, low_thr_r;
  logic [WW-1:0]             w_r, w_clamp;
  logic [RW-1:0]             h_r, h_clamp;
  logic [XW-1:0]             x_r, x_nxt, oc_r, oc_nxt;
  logic [RW-1:0]             row_r, row_nxt, orow_r, orow_nxt;

  logic in_frame, accept, last_col, last_oc, last_orow, row_ge1, row_ge2, emit, frame_end;

  always_comb begin
    if (cfg_wdata == '0) begin
      w_clamp = WW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      h_clamp = RW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
      h_clamp = RW'(MAX_HEIGHT);
    end else begin
      h_clamp = RW'(cfg_wdata);
    end
  end

  assign in_ready  = s1_ready;
  assign accept    = in_valid && in_ready;
  assign in_frame  = row_r < h_r;
  // a flush tick inside the frame is taken and dropped
  assign acc       = accept && !(in_frame && (in_op == hth_pkg::OP_FLUSH));

  assign row_ge1   = row_r != '0;
  assign row_ge2   = 32'(row_r) >= 32'd2;
  assign last_col  = (WW'(x_r) + WW'(1)) == w_r;
  assign last_oc   = (WW'(oc_r) + WW'(1)) == w_r;
  assign last_orow = (orow_r + RW'(1)) == h_r;
  assign emit      = row_ge2 || ((row_r == RW'(1)) && (x_r != '0));
  assign frame_end = emit && last_oc && last_orow;

  always_comb begin
    pkt.flags     = in_frame ? hth_pkg::classify(in_pixel, high_thr_r, low_thr_r) : '0;
    pkt.first_col = (x_r == '0);
    pkt.row_ge1   = row_ge1;
    pkt.row_ge2   = row_ge2;
    pkt.emit      = emit;
    pkt.frame_end = frame_end;
    pkt_x         = x_r;
  end

  always_comb begin
    x_nxt    = x_r;
    row_nxt  = row_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    if (acc) begin
      if (frame_end) begin
        x_nxt    = '0;
        row_nxt  = '0;
        oc_nxt   = '0;
        orow_nxt = '0;
      end else begin
        x_nxt   = last_col ? '0 : x_r + XW'(1);
        row_nxt = last_col ? row_r + RW'(1) : row_r;
        if (emit) begin
          oc_nxt   = last_oc ? '0 : oc_r + XW'(1);
          orow_nxt = last_oc ? orow_r + RW'(1) : orow_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= hth_pkg::HIGH_THR_RST;
      low_thr_r  <= hth_pkg::LOW_THR_RST;
      w_r        <= WW'(W_RST);
      h_r        <= RW'(H_RST);
      x_r        <= '0;
      row_r      <= '0;
      oc_r       <= '0;
      orow_r     <= '0;
    end else begin
      x_r    <= x_nxt;
      row_r  <= row_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
      if (cfg_we) begin
        case (hth_pkg::cfg_idx_t'(cfg_idx))
          hth_pkg::CFG_HIGH_THR: high_thr_r <= cfg_wdata[hth_pkg::THR_W-1:0];
          hth_pkg::CFG_LOW_THR:  low_thr_r  <= cfg_wdata[hth_pkg::THR_W-1:0];
          hth_pkg::CFG_WIDTH: begin
            w_r    <= w_clamp;
            x_r    <= '0;
            row_r  <= '0;
            oc_r   <= '0;
            orow_r <= '0;
          end
          hth_pkg::CFG_HEIGHT: begin
            h_r    <= h_clamp;
            x_r    <= '0;
            row_r  <= '0;
            oc_r   <= '0;
            orow_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/hth_line_mem.sv =====
// Line store: one entry per column holding the flags of the two rows above.
// Depends on hth_pkg.
module hth_line_mem #(
  parameter int DEPTH = hth_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output hth_pkg::row_ent_t rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  hth_pkg::row_ent_t wr_data
);

  hth_pkg::row_ent_t mem [DEPTH];
  hth_pkg::row_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the consumer stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hth_window.sv =====
// Window stage: merges line-store data, shifts the 3x3 window, decides the edge, output register.
// Depends on hth_pkg; drives the write port of hth_line_mem.
module hth_window #(
  parameter int MAX_WIDTH = hth_pkg::MAX_WIDTH_DEF,
  localparam int XW = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  hth_pkg::pix_pkt_t pkt,
  input  logic [XW-1:0]     pkt_x,
  output logic              s1_ready,
  input  hth_pkg::row_ent_t rd_data,
  output logic              wr_en,
  output logic [XW-1:0]     wr_addr,
  output hth_pkg::row_ent_t wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_edge_res,
  output logic              out_frame_end
);

  logic              s1_vld_r, s1_fire;
  hth_pkg::pix_pkt_t s1_pkt_r;
  logic [XW-1:0]     s1_x_r;
  logic              fwd_r;
  hth_pkg::row_ent_t fwd_data_r, ent;
  hth_pkg::window_t  win_r, base, win_nxt, probe;
  logic [1:0]        top, mid;
  logic              out_vld_r, edge_r, fend_r, edge_c;

  assign s1_fire  = s1_vld_r && (!s1_pkt_r.emit || !out_vld_r || out_ready);
  assign s1_ready = !s1_vld_r || s1_fire;

  always_comb begin
    // take the write-back of the previous beat when it hit the same column
    ent     = fwd_r ? fwd_data_r : rd_data;
    top     = s1_pkt_r.row_ge2 ? ent[1:0] : 2'b00;
    mid     = s1_pkt_r.row_ge1 ? ent[3:2] : 2'b00;
    base    = s1_pkt_r.first_col ? '0 : win_r;
    win_nxt = {s1_pkt_r.flags, mid, top, base[17:6]};
    probe   = s1_pkt_r.first_col ? {6'b000000, win_r[17:6]} : win_nxt;
    edge_c  = hth_pkg::centre_edge(probe);
    wr_en   = s1_fire;
    wr_addr = s1_x_r;
    wr_data = {s1_pkt_r.flags, ent[3:2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
      out_vld_r <= 1'b0;
      win_r     <= '0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
        fwd_r    <= s1_fire && (s1_x_r == pkt_x);
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        win_r <= win_nxt;
      end
      if (s1_fire && s1_pkt_r.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pkt_r   <= pkt;
      s1_x_r     <= pkt_x;
      fwd_data_r <= wr_data;
    end
    if (s1_fire && s1_pkt_r.emit) begin
      edge_r <= edge_c;
      fend_r <= s1_pkt_r.frame_end;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_edge_res  = edge_r;
  assign out_frame_end = fend_r;

endmodule

// ===== rtl/hysteresis_threshold_3x3.sv =====
// Top level of the 3x3 hysteresis threshold block.
// Depends on hth_pkg, hth_in_if, hth_out_if, hth_front, hth_line_mem and hth_window.
//
// Greyscale pixels arrive in raster order, one beat each, and the block takes one beat every
// clock unless the result channel stalls it: the front stage classes a beat and issues the
// line-store read, and the window stage registers it and finishes it into the result register,
// so throughput stays at one beat per clock. The single-port-read line store (one four-bit
// entry per column, read when a beat is accepted and written back by the window stage) sets
// that rhythm; a column that is read while its previous write is still in flight (a frame
// one pixel wide) is served by forwarding. A pixel is strong when above the high threshold or at
// full level, a candidate when its clamped level is above the low threshold, and a result is 1
// for a candidate centre with at least one strong in-image neighbour. Results lag input by one
// row plus one pixel; after the last pixel, send flush beats (op = 1) to drain the tail, and
// frame_end marks the last result of the frame. Flush beats inside the frame are taken and
// dropped. Write configuration only while idle: a size write restarts the frame, threshold
// writes take effect at once. Line-store contents need no clearing after reset.
module hysteresis_threshold_3x3 #(
  parameter int MAX_WIDTH  = hth_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hth_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hth_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hth_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  hth_in_if.sink                          in_ch,
  hth_out_if.source                       out_ch
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic              s1_ready, acc;
  hth_pkg::pix_pkt_t pkt;
  logic [XW-1:0]     pkt_x;
  hth_pkg::row_ent_t rd_data, wr_data;
  logic              wr_en;
  logic [XW-1:0]     wr_addr;

  // front stage: registers, position counters, classing
  hth_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_pixel  (in_ch.pixel),
    .in_ready  (in_ch.ready),
    .s1_ready  (s1_ready),
    .acc       (acc),
    .pkt       (pkt),
    .pkt_x     (pkt_x)
  );

  // line store: read on the accepted beat, written back by the window stage
  hth_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (pkt_x),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // window stage and result register
  hth_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .pkt           (pkt),
    .pkt_x         (pkt_x),
    .s1_ready      (s1_ready),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_edge_res  (out_ch.edge_res),
    .out_frame_end (out_ch.frame_end)
  );

endmodule

// ===== test/hysteresis_threshold_3x3_test.sv =====
// Self-checking test of hysteresis_threshold_3x3: streams raster pixels and flush beats,
// predicts each edge result in-bench and checks it beat by beat on the result channel.
// Depends on hth_pkg, hth_in_if, hth_out_if and the block under test.
module hysteresis_threshold_3x3_test;

  localparam int PW = hth_pkg::PIX_W;
  localparam int DW = hth_pkg::CFG_DATA_W;

  // work beats for the random frames; the directed tests bring the run to about 850
  localparam int ITEM_TARGET      = 640;
  localparam int SHOWN_MISMATCHES = 10;
  // let the pipe empty with a little margin before touching config
  localparam int SETTLE_CYCLES    = 4;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  hth_pkg::cfg_idx_t cfg_idx;
  logic [DW-1:0]     cfg_wdata;

  hth_in_if  pix_ch();
  hth_out_if res_ch();

  hysteresis_threshold_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pix_ch),
    .out_ch    (res_ch)
  );

  typedef struct packed {
    logic edge_res;
    logic frame_end;
  } edge_beat_t;

  // edge results still owed by the block, oldest first
  edge_beat_t  expected_edges[$];
  int          mismatches = 0;
  int unsigned work_beats = 0;  // beats that did something (ignored flushes excluded)
  bit          send_gaps  = 1'b1;
  bit          recv_gaps  = 1'b1;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers, the two line stores, the
  // 3x3 window and the raster position.
  // ---------------------------------------------------------------------------
  logic [hth_pkg::THR_W-1:0] hi_thr     = hth_pkg::HIGH_THR_RST;
  logic [hth_pkg::THR_W-1:0] lo_thr     = hth_pkg::LOW_THR_RST;
  logic [DW-1:0]             width_reg  = DW'(hth_pkg::WIDTH_RST);
  logic [DW-1:0]             height_reg = DW'(hth_pkg::HEIGHT_RST);
  hth_pkg::flags_t           line_top [hth_pkg::MAX_WIDTH_DEF] = '{default: '0};  // two up
  hth_pkg::flags_t           line_mid [hth_pkg::MAX_WIDTH_DEF] = '{default: '0};  // one up
  hth_pkg::window_t          win        = '0;
  int unsigned               col_pos    = 0;
  int unsigned               row_pos    = 0;
  int unsigned               emitted    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [DW-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_pixels();
    return clamp_dim(width_reg, hth_pkg::MAX_WIDTH_DEF) *
           clamp_dim(height_reg, hth_pkg::MAX_HEIGHT_DEF);
  endfunction

  function automatic void rewind_frame();
    win     = '0;
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
  endfunction

  // strong: above the high threshold or at full level; candidate: clamped level
  // above the low threshold
  function automatic hth_pkg::flags_t grade_pixel(logic [PW-1:0] pix);
    logic            is_strong;
    logic [PW-1:0]   level;
    hth_pkg::flags_t f;
    is_strong = (pix > hi_thr) || (pix == hth_pkg::FULL_LEVEL);
    level     = is_strong ? hth_pkg::FULL_LEVEL : pix;
    f[hth_pkg::FLAG_STRONG_BIT] = is_strong;
    f[hth_pkg::FLAG_CAND_BIT]   = (level > lo_thr);
    return f;
  endfunction

  // centre candidate with a strong neighbour; the centre's own strength is ignored
  function automatic logic centre_fires(hth_pkg::window_t w);
    logic near_strong;
    int   c;
    near_strong = 1'b0;
    for (c = 0; c < 9; c++)
      if (c != 4 && w[2*c + hth_pkg::FLAG_STRONG_BIT]) near_strong = 1'b1;
    return w[2*4 + hth_pkg::FLAG_CAND_BIT] && near_strong;
  endfunction

  // Advance the predictor by one accepted beat and queue any result it causes.
  // Return 0 when the beat is a flush inside the frame, which the block drops.
  function automatic bit predict_beat(logic op, logic [PW-1:0] pix);
    int unsigned     w, h, total, x, r, n;
    hth_pkg::flags_t cur, upper, middle;
    logic            fire, hit;
    edge_beat_t      beat;
    w     = clamp_dim(width_reg, hth_pkg::MAX_WIDTH_DEF);
    h     = clamp_dim(height_reg, hth_pkg::MAX_HEIGHT_DEF);
    total = w * h;
    x     = (col_pos >= w) ? 0 : col_pos;
    r     = row_pos;
    n     = r * w + x;
    cur   = '0;
    fire  = 1'b0;
    hit   = 1'b0;
    if (n < total) begin
      if (op == hth_pkg::OP_FLUSH) return 1'b0;
      cur = grade_pixel(pix);
    end
    // at the start of a row, slide in an empty column to finish the last centre
    // of the previous row, then clear the window
    if (x == 0) begin
      win = win >> 6;
      if (n >= w + 1 && emitted < total) begin
        hit  = centre_fires(win);
        fire = 1'b1;
      end
      win = '0;
    end
    upper       = (r >= 2) ? line_top[x] : '0;
    middle      = (r >= 1) ? line_mid[x] : '0;
    line_top[x] = line_mid[x];
    line_mid[x] = cur;
    win         = {cur, middle, upper, win[17:6]};
    if (x != 0 && n >= w + 1 && emitted < total) begin
      hit  = centre_fires(win);
      fire = 1'b1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      r++;
    end
    col_pos = x;
    row_pos = r;
    if (!fire) return 1'b1;
    emitted++;
    beat.edge_res  = hit;
    beat.frame_end = (emitted >= total);
    expected_edges.push_back(beat);
    if (beat.frame_end) rewind_frame();
    return 1'b1;
  endfunction

  function automatic void apply_config(hth_pkg::cfg_idx_t idx, logic [DW-1:0] val);
    case (idx)
      hth_pkg::CFG_HIGH_THR: hi_thr = val[hth_pkg::THR_W-1:0];
      hth_pkg::CFG_LOW_THR:  lo_thr = val[hth_pkg::THR_W-1:0];
      hth_pkg::CFG_WIDTH: begin
        width_reg = val;
        rewind_frame();
      end
      hth_pkg::CFG_HEIGHT: begin
        height_reg = val;
        rewind_frame();
      end
      default: ;
    endcase
  endfunction

  // Pixel levels weighted towards the threshold boundaries and the extremes
  function automatic logic [PW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return hth_pkg::FULL_LEVEL;
      2:       return hi_thr;
      3:       return hi_thr + 8'd1;
      4:       return lo_thr;
      5:       return lo_thr + 8'd1;
      default: return PW'($urandom);
    endcase
  endfunction

  // Threshold write data; upper bits are random too, the block must drop them
  function automatic logic [DW-1:0] pick_threshold_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 11'h0FF;
      2:       return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Present one beat after a random gap, hold it until the block takes it, then
  // predict. Valid stays high between back-to-back beats.
  task automatic send_beat(logic op, logic [PW-1:0] pix);
    int gap;
    gap = send_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.op    <= op;
    pix_ch.pixel <= pix;
    do @(posedge clk); while (!pix_ch.ready);
    if (predict_beat(op, pix)) work_beats++;
  endtask

  // Drop valid and hold until every owed result is in and the pipe has emptied
  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only go in while the block is idle
  task automatic write_reg(hth_pkg::cfg_idx_t idx, logic [DW-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_config(idx, val);
  endtask

  // Push the tail out with a mix of flush beats and surplus pixel beats, both of
  // which act as flushes once the frame's pixels are in
  task automatic drain_frame();
    while (col_pos != 0 || row_pos != 0)
      send_beat(logic'($urandom_range(0, 1)), PW'($urandom));
  endtask

  task automatic send_pixels(int unsigned count);
    repeat (count) send_beat(hth_pkg::OP_PIXEL, pick_level());
  endtask

  // Result side: draw a stall per beat, then hold ready until a beat is taken
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    edge_beat_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result beat: edge_res=%0b frame_end=%0b",
                   res_ch.edge_res, res_ch.frame_end);
      end else begin
        want = expected_edges.pop_front();
        if (want.edge_res !== res_ch.edge_res || want.frame_end !== res_ch.frame_end) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result mismatch: expected edge_res=%0b frame_end=%0b, got %0b %0b",
                     want.edge_res, want.frame_end, res_ch.edge_res, res_ch.frame_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds (200/100) on a small frame. A flush inside the frame must be
  // dropped, and a partial 640x480 frame must vanish when the size is rewritten.
  task automatic test_reset_defaults();
    logic [PW-1:0] levels [6] = '{8'd201, 8'd200, 8'd101, 8'd100, 8'd255, 8'd0};
    send_beat(hth_pkg::OP_FLUSH, 8'd77);
    send_beat(hth_pkg::OP_PIXEL, 8'd255);
    send_beat(hth_pkg::OP_PIXEL, 8'd0);
    write_reg(hth_pkg::CFG_WIDTH, 11'd3);
    write_reg(hth_pkg::CFG_HEIGHT, 11'd2);
    foreach (levels[i]) send_beat(hth_pkg::OP_PIXEL, levels[i]);
    drain_frame();
  endtask

  // Hand-picked 3x3 frame around both thresholds, full level, a flush mid-frame
  // and a surplus pixel beat once the frame is in
  task automatic test_directed_frame();
    logic [PW-1:0] levels [9] = '{8'd0, 8'd151, 8'd150, 8'd255, 8'd51, 8'd50,
                                  8'd255, 8'd0, 8'd200};
    write_reg(hth_pkg::CFG_HIGH_THR, 11'd150);
    write_reg(hth_pkg::CFG_LOW_THR, 11'd50);
    write_reg(hth_pkg::CFG_WIDTH, 11'd3);
    write_reg(hth_pkg::CFG_HEIGHT, 11'd3);
    foreach (levels[i]) begin
      send_beat(hth_pkg::OP_PIXEL, levels[i]);
      if (i == 4) send_beat(hth_pkg::OP_FLUSH, 8'hA5);
    end
    send_beat(hth_pkg::OP_PIXEL, 8'd255);
    drain_frame();
  endtask

  // Thresholds change halfway through a frame; the sender holds off until every
  // owed result has come before the writes
  task automatic test_threshold_midframe();
    write_reg(hth_pkg::CFG_WIDTH, 11'd4);
    write_reg(hth_pkg::CFG_HEIGHT, 11'd3);
    send_pixels(6);
    settle();
    write_reg(hth_pkg::CFG_HIGH_THR, pick_threshold_word());
    write_reg(hth_pkg::CFG_LOW_THR, pick_threshold_word());
    send_pixels(6);
    drain_frame();
  endtask

  // A size write part-way through restarts the frame and drops what was owed
  task automatic test_size_restart();
    write_reg(hth_pkg::CFG_HIGH_THR, 11'd180);
    write_reg(hth_pkg::CFG_LOW_THR, 11'd60);
    write_reg(hth_pkg::CFG_WIDTH, 11'd5);
    write_reg(hth_pkg::CFG_HEIGHT, 11'd3);
    send_pixels(8);
    write_reg(hth_pkg::CFG_HEIGHT, 11'd2);
    send_pixels(10);
    drain_frame();
  endtask

  // Sizes out of range clamp to 1..1024: the start of the widest row, a one-pixel
  // frame, then the start of the tallest column; the long frames are cut short by
  // the next size write
  task automatic test_clamped_sizes();
    write_reg(hth_pkg::CFG_WIDTH, '1);
    write_reg(hth_pkg::CFG_HEIGHT, '0);
    send_pixels(40);
    write_reg(hth_pkg::CFG_WIDTH, '0);
    send_pixels(frame_pixels());
    drain_frame();
    write_reg(hth_pkg::CFG_HEIGHT, '1);
    send_pixels(60);
  endtask

  // Random small frames with random thresholds. Some frames run back to back on
  // the same settings, some are cut short by a size write, and a few carry
  // threshold writes or stray flushes part-way through.
  task automatic test_random_frames();
    int unsigned       start, total, cut, i;
    bit                fresh;
    hth_pkg::cfg_idx_t idx;
    start = work_beats;
    fresh = 1'b1;
    while (work_beats - start < ITEM_TARGET) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      if (fresh || $urandom_range(0, 3) != 0) begin
        write_reg(hth_pkg::CFG_HIGH_THR, pick_threshold_word());
        write_reg(hth_pkg::CFG_LOW_THR, pick_threshold_word());
        if ($urandom_range(0, 9) == 0)
          write_reg(hth_pkg::CFG_WIDTH, DW'($urandom_range(0, 24)));
        else
          write_reg(hth_pkg::CFG_WIDTH, DW'($urandom_range(1, 8)));
        write_reg(hth_pkg::CFG_HEIGHT, DW'($urandom_range(0, 6)));
      end
      total = frame_pixels();
      cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
      for (i = 0; i < cut; i++) begin
        if ($urandom_range(0, 11) == 0) send_beat(hth_pkg::OP_FLUSH, PW'($urandom));
        if ($urandom_range(0, 39) == 0) begin
          idx = $urandom_range(0, 1) ? hth_pkg::CFG_HIGH_THR : hth_pkg::CFG_LOW_THR;
          write_reg(idx, pick_threshold_word());
        end
        send_beat(hth_pkg::OP_PIXEL, pick_level());
      end
      // a cut frame is abandoned: the next pass rewrites the sizes, restarting it
      fresh = (cut < total);
      if (!fresh) drain_frame();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= hth_pkg::CFG_HIGH_THR;
    cfg_wdata    <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.op    <= hth_pkg::OP_PIXEL;
    pix_ch.pixel <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_frame();
    test_threshold_midframe();
    test_size_restart();
    test_clamped_sizes();
    test_random_frames();

    // wait out every owed result plus the pipe depth
    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== hysteresis_threshold_3x3.f =====
rtl/hth_pkg.sv
rtl/hth_in_if.sv
rtl/hth_out_if.sv
rtl/hth_front.sv
rtl/hth_line_mem.sv
rtl/hth_window.sv
rtl/hysteresis_threshold_3x3.sv
test/hysteresis_threshold_3x3_test.sv
